FILE: rtl/scos_pkg.sv
// ----------------------------------------------------------------------------
// Stable cost-order sorter package
// Item types and control bundle shared by the sorter chain and its cells.
// ----------------------------------------------------------------------------
package scos_pkg;

  localparam int unsigned CostW  = 32;
  localparam int unsigned OrdIdxW = 4;
  localparam int unsigned BatchCntW = 5;

  typedef struct packed {
    logic signed [CostW-1:0] op_cost;
    logic                    batch_end;
  } in_item_t;

  typedef struct packed {
    logic [OrdIdxW-1:0]   order_index;
    logic [BatchCntW-1:0] batch_count;
    logic                 run_end;
  } out_item_t;

  // Per-cycle command to every cell of the chain.
  typedef struct packed {
    logic ins;    // an item is placed into the chain this cycle
    logic shift;  // the chain moves one place toward the head (drain)
  } cell_ctrl_t;

endpackage

FILE: rtl/stable_cost_order_sorter_unit.sv
// ----------------------------------------------------------------------------
// Stable cost-order sorter
// Collects a batch of costs into a sorted chain of cells and then emits the
// arrival indices in ascending cost order, ties in arrival order.
// ----------------------------------------------------------------------------
// The first index of a batch is offered in the cycle after the item that
// closes the batch is accepted. Throughput: one input item per cycle while
// collecting, since every cell compares against the new cost in parallel;
// while a batch of N drains, input is held off until all N indices are taken.
// Reset: clears the fill count and drain state; cell contents are not reset.
module stable_cost_order_sorter_unit import scos_pkg::*; #(
  parameter int unsigned MAX_OPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned IdxW = $clog2(MAX_OPS);
  localparam int unsigned CntW = $clog2(MAX_OPS + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] bcnt_q, bcnt_d;
  logic            drain_q, drain_d;
  logic            in_acc, out_acc, room;
  logic [CntW-1:0] n_final;
  cell_ctrl_t      ctrl;

  logic signed [CostW-1:0] cost_w [MAX_OPS];
  logic [IdxW-1:0]         idx_w  [MAX_OPS];
  logic                    gt_w   [MAX_OPS];
  logic                    occ_w  [MAX_OPS];

  logic [IdxW+OrdIdxW-1:0]  idx_ext;
  logic [CntW+BatchCntW-1:0] cnt_ext;

  assign in_ready_o  = !drain_q;
  assign out_valid_o = drain_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign room        = cnt_q < CntW'(MAX_OPS);

  assign ctrl.ins   = in_acc && room;
  assign ctrl.shift = out_acc;

  assign n_final = room ? cnt_q + CntW'(1) : cnt_q;

  for (genvar i = 0; i < MAX_OPS; i++) begin : g_cell
    logic                    prev_occ, prev_gt;
    logic signed [CostW-1:0] prev_cost, next_cost;
    logic [IdxW-1:0]         prev_idx, next_idx;

    assign occ_w[i] = CntW'(i) < cnt_q;

    if (i == 0) begin : g_head
      assign prev_occ  = 1'b1;
      assign prev_gt   = 1'b0;
      assign prev_cost = '0;
      assign prev_idx  = '0;
    end else begin : g_body
      assign prev_occ  = occ_w[i-1];
      assign prev_gt   = gt_w[i-1];
      assign prev_cost = cost_w[i-1];
      assign prev_idx  = idx_w[i-1];
    end

    if (i == MAX_OPS - 1) begin : g_tail
      assign next_cost = '0;
      assign next_idx  = '0;
    end else begin : g_inner
      assign next_cost = cost_w[i+1];
      assign next_idx  = idx_w[i+1];
    end

    scos_cell #(
      .IdxW(IdxW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .new_cost_i (in_item_i.op_cost),
      .new_idx_i  (cnt_q[IdxW-1:0]),
      .occ_i      (occ_w[i]),
      .prev_occ_i (prev_occ),
      .prev_gt_i  (prev_gt),
      .prev_cost_i(prev_cost),
      .prev_idx_i (prev_idx),
      .next_cost_i(next_cost),
      .next_idx_i (next_idx),
      .gt_o       (gt_w[i]),
      .cost_o     (cost_w[i]),
      .idx_o      (idx_w[i])
    );
  end

  always_comb begin
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    bcnt_d  = bcnt_q;
    drain_d = drain_q;
    if (in_acc) begin
      if (in_item_i.batch_end) begin
        cnt_d   = '0;
        rem_d   = n_final;
        bcnt_d  = n_final;
        drain_d = 1'b1;
      end else if (room) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
    if (out_acc) begin
      rem_d = rem_q - CntW'(1);
      if (rem_q == CntW'(1)) begin
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      rem_q   <= '0;
      bcnt_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      bcnt_q  <= bcnt_d;
      drain_q <= drain_d;
    end
  end

  // The result fields are masked or zero-extended to their fixed widths.
  assign idx_ext = {{OrdIdxW{1'b0}}, idx_w[0]};
  assign cnt_ext = {{BatchCntW{1'b0}}, bcnt_q};

  assign out_item_o.order_index = idx_ext[OrdIdxW-1:0];
  assign out_item_o.batch_count = cnt_ext[BatchCntW-1:0];
  assign out_item_o.run_end     = rem_q == CntW'(1);

endmodule

FILE: rtl/scos_cell.sv
// ----------------------------------------------------------------------------
// Sorter chain cell
// Holds one cost and its arrival index; takes the new item, its left
// neighbor's entry on insertion, or its right neighbor's entry on drain.
// ----------------------------------------------------------------------------
module scos_cell import scos_pkg::*; #(
  parameter int unsigned IdxW = 4
) (
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [CostW-1:0] new_cost_i,
  input  logic [IdxW-1:0]         new_idx_i,
  input  logic                    occ_i,
  input  logic                    prev_occ_i,
  input  logic                    prev_gt_i,
  input  logic signed [CostW-1:0] prev_cost_i,
  input  logic [IdxW-1:0]         prev_idx_i,
  input  logic signed [CostW-1:0] next_cost_i,
  input  logic [IdxW-1:0]         next_idx_i,
  output logic                    gt_o,
  output logic signed [CostW-1:0] cost_o,
  output logic [IdxW-1:0]         idx_o
);

  logic signed [CostW-1:0] cost_q;
  logic [IdxW-1:0]         idx_q;
  logic                    take_prev, take_new;

  // Held entries are sorted, so the cells holding a larger cost form a
  // suffix of the occupied ones. Equal costs stay ahead of the new item.
  assign gt_o = occ_i && (cost_q > new_cost_i);

  always_comb begin
    take_prev = ctrl_i.ins && prev_gt_i;
    take_new  = ctrl_i.ins && !prev_gt_i && (gt_o || (!occ_i && prev_occ_i));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      cost_q <= next_cost_i;
      idx_q  <= next_idx_i;
    end else if (take_prev) begin
      cost_q <= prev_cost_i;
      idx_q  <= prev_idx_i;
    end else if (take_new) begin
      cost_q <= new_cost_i;
      idx_q  <= new_idx_i;
    end
  end

  assign cost_o = cost_q;
  assign idx_o  = idx_q;

endmodule
